// ===== src/wfmha_pkg.sv =====
// ----------------------------------------------------------------------------
// wfmha_pkg
// Shared constants for the worst-fit max-heap allocator.
// ----------------------------------------------------------------------------
package wfmha_pkg;

    localparam int AMOUNT_W    = 16;
    localparam int BIN_INDEX_W = 6;

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_ALLOC = 1'b1;

endpackage

// ===== src/worst_fit_max_heap_allocator_top.sv =====
// ----------------------------------------------------------------------------
// worst_fit_max_heap_allocator_top
// Worst-fit bin allocator on a binary max-heap held in one memory.
// ----------------------------------------------------------------------------
// Each heap entry holds a bin's remaining capacity and its index; the root is
// the bin with the most room, lower index first on a tie. An add transaction
// appends a bin and sifts it up; an allocate transaction checks the root,
// charges it and sifts it down, giving one result (bin or rejected). The
// block takes one transaction at a time. Every heap level costs one memory
// read round trip, then a compare and write back; a sift moves at most
// log2(NUM_BINS) levels. An add to a full table is dropped. A finished
// result sits in an output register while the next transaction is taken;
// an allocate waits until that register is free.
module worst_fit_max_heap_allocator_top #(
    parameter int NUM_BINS = 64,
    parameter int CAP_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_operation,
    input  logic [wfmha_pkg::AMOUNT_W-1:0]      i_amount,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_rejected,
    output logic [wfmha_pkg::BIN_INDEX_W-1:0]   o_bin_index
);

    localparam int BW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam int CW = $clog2(NUM_BINS + 1);
    localparam int EW = CAP_BITS + BW;

    typedef struct packed {
        logic [CAP_BITS-1:0] cap;
        logic [BW-1:0]       bin;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_ROOT,
        S_DN_RD,
        S_DN_CMP
    } t_state;

    function automatic logic f_above(t_entry a, t_entry b);
        return (a.cap > b.cap) || ((a.cap == b.cap) && (a.bin < b.bin));
    endfunction

    t_state                                r_state, n_state;
    logic [CW-1:0]                         r_count, n_count;
    logic [BW-1:0]                         r_pos, n_pos;
    t_entry                                r_cur, n_cur;
    logic [CAP_BITS-1:0]                   r_amount, n_amount;
    logic                                  r_out_valid, n_out_valid;
    logic                                  r_rejected, n_rejected;
    logic [wfmha_pkg::BIN_INDEX_W-1:0]     r_bin, n_bin;

    logic          w_we;
    logic [BW-1:0] w_waddr;
    t_entry        w_wdata;
    logic [BW-1:0] w_raddr_a;
    logic [EW-1:0] w_rdata_a, w_rdata_b;
    t_entry        w_ent_a, w_ent_b, w_best;
    logic [BW-1:0] w_parent;
    logic [BW+1:0] w_left, w_right;
    logic          w_left_ok, w_right_ok, w_take_l, w_take_r;
    logic          w_out_free;

    assign w_ent_a    = t_entry'(w_rdata_a);
    assign w_ent_b    = t_entry'(w_rdata_b);
    assign w_parent   = (r_pos - BW'(1)) >> 1;
    assign w_left     = {1'b0, r_pos, 1'b1};
    assign w_right    = w_left + (BW+2)'(1);
    assign w_left_ok  = w_left < (BW+2)'(r_count);
    assign w_right_ok = w_right < (BW+2)'(r_count);
    assign w_take_l   = w_left_ok && f_above(w_ent_a, r_cur);
    assign w_best     = w_take_l ? w_ent_a : r_cur;
    assign w_take_r   = w_right_ok && f_above(w_ent_b, w_best);
    assign w_out_free = !r_out_valid || i_out_ready;

    assign w_raddr_a = (r_state == S_UP_RD) ? w_parent :
                       (r_state == S_DN_RD) ? w_left[BW-1:0] : '0;

    wfmha_heap_ram #(
        .DEPTH (NUM_BINS),
        .AW    (BW),
        .DW    (EW)
    ) u_heap_ram (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_raddr_a (w_raddr_a),
        .i_raddr_b (w_right[BW-1:0]),
        .o_rdata_a (w_rdata_a),
        .o_rdata_b (w_rdata_b)
    );

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_pos       = r_pos;
        n_cur       = r_cur;
        n_amount    = r_amount;
        n_out_valid = r_out_valid && !i_out_ready;
        n_rejected  = r_rejected;
        n_bin       = r_bin;
        w_we        = 1'b0;
        w_waddr     = r_pos;
        w_wdata     = r_cur;
        o_in_ready  = (r_state == S_IDLE);

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_amount = CAP_BITS'(i_amount);
                    if (i_operation == wfmha_pkg::OP_ADD) begin
                        if (r_count != CW'(NUM_BINS)) begin
                            n_cur.cap = CAP_BITS'(i_amount);
                            n_cur.bin = r_count[BW-1:0];
                            n_pos     = r_count[BW-1:0];
                            n_count   = r_count + CW'(1);
                            n_state   = S_UP_RD;
                        end
                    end else begin
                        n_state = S_ROOT;
                    end
                end
            end
            S_UP_RD: begin
                if (r_pos == '0) begin
                    w_we    = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                w_we = 1'b1;
                if (f_above(r_cur, w_ent_a)) begin
                    w_wdata = w_ent_a;
                    n_pos   = w_parent;
                    n_state = S_UP_RD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_ROOT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    if ((r_count == '0) || (w_ent_a.cap < r_amount)) begin
                        n_rejected = 1'b1;
                        n_bin      = '0;
                        n_state    = S_IDLE;
                    end else begin
                        n_rejected = 1'b0;
                        n_bin      = wfmha_pkg::BIN_INDEX_W'(w_ent_a.bin);
                        n_cur.cap  = w_ent_a.cap - r_amount;
                        n_cur.bin  = w_ent_a.bin;
                        n_pos      = '0;
                        n_state    = S_DN_RD;
                    end
                end
            end
            S_DN_RD: begin
                n_state = S_DN_CMP;
            end
            S_DN_CMP: begin
                w_we = 1'b1;
                if (w_take_r) begin
                    w_wdata = w_ent_b;
                    n_pos   = w_right[BW-1:0];
                    n_state = S_DN_RD;
                end else if (w_take_l) begin
                    w_wdata = w_ent_a;
                    n_pos   = w_left[BW-1:0];
                    n_state = S_DN_RD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_pos      <= n_pos;
        r_cur      <= n_cur;
        r_amount   <= n_amount;
        r_rejected <= n_rejected;
        r_bin      <= n_bin;
    end

    assign o_out_valid = r_out_valid;
    assign o_rejected  = r_rejected;
    assign o_bin_index = r_bin;

endmodule

// ===== src/wfmha_heap_ram.sv =====
// ----------------------------------------------------------------------------
// wfmha_heap_ram
// Heap storage: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module wfmha_heap_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int DW    = 22
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr_a,
    input  logic [AW-1:0] i_raddr_b,
    output logic [DW-1:0] o_rdata_a,
    output logic [DW-1:0] o_rdata_b
);

    logic [DW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule
